// ----- design/gtsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gtsc_pkg;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RUN_LIMIT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COOLDOWN_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_PER_SEC  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CRANK_SECONDS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_SECONDS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_SECONDS   = 3'd5;

   // Register reset values
   localparam logic [15:0] RUN_LIMIT_RST      = 16'd14388;
   localparam logic [15:0] COOLDOWN_LIMIT_RST = 16'd3599;
   localparam logic [15:0] TICKS_PER_SEC_RST  = 16'd1953;
   localparam logic [7:0]  CRANK_SECONDS_RST  = 8'd5;
   localparam logic [7:0]  SETTLE_SECONDS_RST = 8'd5;
   localparam logic [7:0]  HOLD_SECONDS_RST   = 8'd2;

   // Item kinds
   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_SCAN = 2'd1;
   localparam logic [1:0] KIND_STOP = 2'd2;

   // Button scan mode codes
   localparam logic [2:0] CODE_MAINTAIN = 3'd0;
   localparam logic [2:0] CODE_START    = 3'd2;
   localparam logic [2:0] CODE_AUTO     = 3'd4;
   localparam logic [2:0] CODE_AUTO_ALT = 3'd6;
   localparam logic [2:0] CODE_OFF      = 3'd7;

   // Relay bit positions
   localparam int R_STOP   = 0;
   localparam int R_CHANGE = 1;
   localparam int R_START  = 2;
   localparam int R_ON     = 3;

   // Timed phases
   typedef enum logic [5:0] {
      PH_IDLE       = 6'b000001,
      PH_OFF_HOLD   = 6'b000010,
      PH_MAINS_HOLD = 6'b000100,
      PH_WAIT       = 6'b001000,
      PH_CRANK      = 6'b010000,
      PH_SETTLE     = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [15:0] run_limit;
      logic [15:0] cooldown_limit;
      logic [15:0] ticks_per_second;
      logic [7:0]  crank_seconds;
      logic [7:0]  settle_seconds;
      logic [7:0]  hold_seconds;
   } cfg_type;

   typedef struct packed {
      logic stop_relay;
      logic changeover_relay;
      logic start_relay;
      logic on_relay;
      logic square_out;
      logic running;
      logic cooling;
      logic auto_mode;
   } result_type;

endpackage

`default_nettype wire

// ----- design/gtsc_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gtsc_csr
   import gtsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [CSR_IDX_W-1:0]   idx;

   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_RUN_LIMIT:      cfg_in.run_limit        = pwdata[15:0];
            REG_COOLDOWN_LIMIT: cfg_in.cooldown_limit   = pwdata[15:0];
            REG_TICKS_PER_SEC:  cfg_in.ticks_per_second = pwdata[15:0];
            REG_CRANK_SECONDS:  cfg_in.crank_seconds    = pwdata[7:0];
            REG_SETTLE_SECONDS: cfg_in.settle_seconds   = pwdata[7:0];
            REG_HOLD_SECONDS:   cfg_in.hold_seconds     = pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_limit        <= RUN_LIMIT_RST;
         cfg_ff.cooldown_limit   <= COOLDOWN_LIMIT_RST;
         cfg_ff.ticks_per_second <= TICKS_PER_SEC_RST;
         cfg_ff.crank_seconds    <= CRANK_SECONDS_RST;
         cfg_ff.settle_seconds   <= SETTLE_SECONDS_RST;
         cfg_ff.hold_seconds     <= HOLD_SECONDS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back multiplexer
   always_comb begin
      unique case (idx)
         REG_RUN_LIMIT:      prdata = {16'd0, cfg_ff.run_limit};
         REG_COOLDOWN_LIMIT: prdata = {16'd0, cfg_ff.cooldown_limit};
         REG_TICKS_PER_SEC:  prdata = {16'd0, cfg_ff.ticks_per_second};
         REG_CRANK_SECONDS:  prdata = {24'd0, cfg_ff.crank_seconds};
         REG_SETTLE_SECONDS: prdata = {24'd0, cfg_ff.settle_seconds};
         REG_HOLD_SECONDS:   prdata = {24'd0, cfg_ff.hold_seconds};
         default:            prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- design/gtsc_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gtsc_step
   import gtsc_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire logic [1:0] kind,
   input  wire logic [2:0] buttons,
   input  wire logic       mains_present,
   input  wire cfg_type    cfg,
   output result_type      result
);

   localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

   logic [TIMER_WIDTH-1:0] tick_ff,  tick_in;
   logic [15:0]            run_ff,   run_in;
   logic [15:0]            cool_ff,  cool_in;
   logic                   rflag_ff, rflag_in;
   logic                   cflag_ff, cflag_in;
   logic                   auto_ff,  auto_in;
   logic                   offl_ff,  offl_in;
   logic                   sq_ff,    sq_in;
   logic [3:0]             relay_ff, relay_in;
   phase_type              phase_ff, phase_in;
   logic [7:0]             psec_ff,  psec_in;

   // Next state for one item, applied in the order of the control sequence
   always_comb begin
      logic [TIMER_WIDTH-1:0] tick_inc;
      logic                   second;
      logic [2:0]             code;

      tick_inc = tick_ff + 1'b1;
      second   = 1'b0;
      code     = buttons;

      tick_in  = tick_ff;
      run_in   = run_ff;
      cool_in  = cool_ff;
      rflag_in = rflag_ff;
      cflag_in = cflag_ff;
      auto_in  = auto_ff;
      offl_in  = offl_ff;
      sq_in    = sq_ff;
      relay_in = relay_ff;
      phase_in = phase_ff;
      psec_in  = psec_ff;

      unique case (kind)
         KIND_TICK: begin
            tick_in = tick_inc;
            if (CMP_W'(tick_inc) == CMP_W'(cfg.ticks_per_second)) begin
               tick_in = '0;
               second  = 1'b1;
            end
         end
         KIND_SCAN: begin
            if (phase_ff == PH_IDLE) begin
               if (offl_ff || (!rflag_ff && cflag_ff)) begin
                  code = CODE_OFF;
               end
               if (code == CODE_AUTO || code == CODE_AUTO_ALT) begin
                  auto_in = 1'b1;
                  if (mains_present) begin
                     relay_in[R_CHANGE] = 1'b0;
                     phase_in = PH_MAINS_HOLD;
                     psec_in  = cfg.hold_seconds;
                  end else begin
                     phase_in = PH_WAIT;
                     psec_in  = 8'd1;
                  end
               end else if (code == CODE_START) begin
                  auto_in            = 1'b0;
                  relay_in[R_STOP]   = 1'b1;
                  relay_in[R_ON]     = 1'b1;
                  relay_in[R_START]  = 1'b1;
                  rflag_in           = 1'b1;
               end else if (code == CODE_MAINTAIN) begin
                  relay_in[R_START] = 1'b0;
                  auto_in           = 1'b0;
               end else begin
                  auto_in  = 1'b0;
                  phase_in = PH_OFF_HOLD;
                  psec_in  = cfg.hold_seconds;
               end
            end
         end
         KIND_STOP: begin
            offl_in  = 1'b1;
            auto_in  = 1'b0;
            rflag_in = 1'b0;
         end
         default: begin
            tick_in = tick_ff;
         end
      endcase

      // One second: run and cooldown timers, square wave, timed phase
      if (second) begin
         if (run_ff == cfg.run_limit) begin
            run_in   = '0;
            rflag_in = 1'b0;
            cflag_in = 1'b1;
         end
         if (cool_ff == cfg.cooldown_limit) begin
            cool_in  = '0;
            cflag_in = 1'b0;
         end
         if (rflag_in) run_in  = run_in + 16'd1;
         if (cflag_in) cool_in = cool_in + 16'd1;
         sq_in = ~sq_ff;
         if (phase_ff != PH_IDLE) begin
            if (psec_ff <= 8'd1) begin
               phase_in = PH_IDLE;
               psec_in  = '0;
               unique case (phase_ff)
                  PH_OFF_HOLD: begin
                     relay_in = '0;
                     rflag_in = 1'b0;
                     offl_in  = 1'b0;
                  end
                  PH_MAINS_HOLD: begin
                     offl_in = 1'b1;
                  end
                  PH_WAIT: begin
                     if (!rflag_in && !cflag_in) begin
                        relay_in[R_STOP]  = 1'b1;
                        relay_in[R_ON]    = 1'b1;
                        relay_in[R_START] = 1'b1;
                        phase_in = PH_CRANK;
                        psec_in  = cfg.crank_seconds;
                     end
                  end
                  PH_CRANK: begin
                     rflag_in          = 1'b1;
                     relay_in[R_START] = 1'b0;
                     phase_in = PH_SETTLE;
                     psec_in  = cfg.settle_seconds;
                  end
                  PH_SETTLE: begin
                     if (!mains_present) begin
                        relay_in[R_CHANGE] = 1'b1;
                        rflag_in           = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end else begin
               psec_in = psec_ff - 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         run_ff   <= '0;
         cool_ff  <= '0;
         rflag_ff <= 1'b0;
         cflag_ff <= 1'b0;
         auto_ff  <= 1'b0;
         offl_ff  <= 1'b0;
         sq_ff    <= 1'b0;
         relay_ff <= '0;
         phase_ff <= PH_IDLE;
         psec_ff  <= '0;
      end else if (step_en) begin
         tick_ff  <= tick_in;
         run_ff   <= run_in;
         cool_ff  <= cool_in;
         rflag_ff <= rflag_in;
         cflag_ff <= cflag_in;
         auto_ff  <= auto_in;
         offl_ff  <= offl_in;
         sq_ff    <= sq_in;
         relay_ff <= relay_in;
         phase_ff <= phase_in;
         psec_ff  <= psec_in;
      end
   end

   // The result reflects the state after this item
   always_comb begin
      result.stop_relay       = relay_in[R_STOP];
      result.changeover_relay = relay_in[R_CHANGE];
      result.start_relay      = relay_in[R_START];
      result.on_relay         = relay_in[R_ON];
      result.square_out       = sq_in;
      result.running          = rflag_in;
      result.cooling          = cflag_in;
      result.auto_mode        = auto_in;
   end

endmodule

`default_nettype wire

// ----- design/generator_transfer_switch_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

// An accepted item is held in the input register, then its result in the result
// register.
// Throughput: one item per cycle; the state update is a single pass between the
// two registers, so nothing but a stalled result register holds the input back.
// Reset (synchronous, active high) clears all timers, flags, relays and the phase
// and loads the configuration registers with their defaults.

module generator_transfer_switch_ctrl
   import gtsc_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_kind,
   input  wire logic [2:0]            req_buttons,
   input  wire logic                  req_mains_present,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_stop_relay,
   output logic                       rsp_changeover_relay,
   output logic                       rsp_start_relay,
   output logic                       rsp_on_relay,
   output logic                       rsp_square_out,
   output logic                       rsp_running,
   output logic                       rsp_cooling,
   output logic                       rsp_auto_mode,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type    cfg;
   result_type step_res;
   result_type res_ff;
   logic       in_valid_ff;
   logic [1:0] kind_ff;
   logic [2:0] buttons_ff;
   logic       mains_ff;
   logic       out_valid_ff;
   logic       advance;
   logic       accept;

   // An item moves on when the result register is empty or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   gtsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gtsc_step #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .kind          (kind_ff),
      .buttons       (buttons_ff),
      .mains_present (mains_ff),
      .cfg           (cfg),
      .result        (step_res)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_kind;
         buttons_ff <= req_buttons;
         mains_ff   <= req_mains_present;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= step_res;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_stop_relay       = res_ff.stop_relay;
   assign rsp_changeover_relay = res_ff.changeover_relay;
   assign rsp_start_relay      = res_ff.start_relay;
   assign rsp_on_relay         = res_ff.on_relay;
   assign rsp_square_out       = res_ff.square_out;
   assign rsp_running          = res_ff.running;
   assign rsp_cooling          = res_ff.cooling;
   assign rsp_auto_mode        = res_ff.auto_mode;

`ifndef SYNTHESIS
   // Every item that moves on shows a result in the next cycle
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item did not reach the result register");

   // The input side stalls only while an item waits behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a held result");

   // A held result leaves the waiting item in place
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |=> in_valid_ff)
      else $error("waiting item lost behind a held result");
`endif

endmodule

`default_nettype wire

// ----- bench/transfer_switch_checker.sv -----
`timescale 1ns / 1ps

// Watches the item and result channels and the register port of the transfer
// switch controller, works out the relay state that each accepted item should
// produce and compares every accepted result with the oldest one still due.
module transfer_switch_checker
   import gtsc_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [2:0]            req_buttons,
   input  logic                  req_mains_present,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_stop_relay,
   input  logic                  rsp_changeover_relay,
   input  logic                  rsp_start_relay,
   input  logic                  rsp_on_relay,
   input  logic                  rsp_square_out,
   input  logic                  rsp_running,
   input  logic                  rsp_cooling,
   input  logic                  rsp_auto_mode,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    mismatch_count,
   output int                    outstanding
);

   // Field names in the bit order of the packed result, most significant first.
   string field_name [8] = '{"stop_relay", "changeover_relay", "start_relay", "on_relay",
                             "square_out", "running", "cooling", "auto_mode"};

   // Our own copy of the configuration and of the controller state.
   cfg_type                cfg;
   logic [TIMER_WIDTH-1:0] tick_cnt;
   logic [15:0]            run_cnt;
   logic [15:0]            cool_cnt;
   logic                   run_on;
   logic                   cool_on;
   logic                   auto_on;
   logic                   off_latch;
   logic                   square;
   logic [3:0]             relays;
   phase_type              phase;
   logic [7:0]             phase_left;

   result_type relay_states_due [$];
   int         fail_total   = 0;
   int         result_index = 0;

   function automatic void clear_controller();
      cfg.run_limit        = RUN_LIMIT_RST;
      cfg.cooldown_limit   = COOLDOWN_LIMIT_RST;
      cfg.ticks_per_second = TICKS_PER_SEC_RST;
      cfg.crank_seconds    = CRANK_SECONDS_RST;
      cfg.settle_seconds   = SETTLE_SECONDS_RST;
      cfg.hold_seconds     = HOLD_SECONDS_RST;
      tick_cnt   = '0;
      run_cnt    = '0;
      cool_cnt   = '0;
      run_on     = 1'b0;
      cool_on    = 1'b0;
      auto_on    = 1'b0;
      off_latch  = 1'b0;
      square     = 1'b0;
      relays     = '0;
      phase      = PH_IDLE;
      phase_left = '0;
   endfunction

   function automatic void open_phase(input phase_type ph, input logic [7:0] secs);
      phase      = ph;
      phase_left = secs;
   endfunction

   // A timed phase has run out: act on what it was waiting for.
   function automatic void close_phase(input logic mains);
      phase_type done_ph;
      done_ph    = phase;
      phase      = PH_IDLE;
      phase_left = '0;
      case (done_ph)
         PH_OFF_HOLD: begin
            relays    = '0;
            run_on    = 1'b0;
            off_latch = 1'b0;
         end
         PH_MAINS_HOLD: begin
            off_latch = 1'b1;
         end
         PH_WAIT: begin
            // Cranking only starts from a fully stopped and cooled engine.
            if (!run_on && !cool_on) begin
               relays[R_STOP]  = 1'b1;
               relays[R_ON]    = 1'b1;
               relays[R_START] = 1'b1;
               open_phase(PH_CRANK, cfg.crank_seconds);
            end
         end
         PH_CRANK: begin
            run_on          = 1'b1;
            relays[R_START] = 1'b0;
            open_phase(PH_SETTLE, cfg.settle_seconds);
         end
         PH_SETTLE: begin
            if (!mains) begin
               relays[R_CHANGE] = 1'b1;
               run_on           = 1'b1;
            end
         end
         default: begin
         end
      endcase
   endfunction

   // One whole second: run and cooldown timers, square wave, timed phase.
   function automatic void count_second(input logic mains);
      if (run_cnt == cfg.run_limit) begin
         run_cnt = '0;
         run_on  = 1'b0;
         cool_on = 1'b1;
      end
      if (cool_cnt == cfg.cooldown_limit) begin
         cool_cnt = '0;
         cool_on  = 1'b0;
      end
      if (run_on) run_cnt = run_cnt + 16'd1;
      if (cool_on) cool_cnt = cool_cnt + 16'd1;
      square = ~square;
      if (phase != PH_IDLE) begin
         if (phase_left <= 8'd1) close_phase(mains);
         else phase_left = phase_left - 8'd1;
      end
   endfunction

   // Button scan; a scan that arrives while a timed phase runs changes nothing.
   function automatic void take_scan(input logic [2:0] buttons, input logic mains);
      logic [2:0] code;
      code = buttons;
      if (phase == PH_IDLE) begin
         // A latched stop or a cooldown without running forces the off path.
         if (off_latch || (!run_on && cool_on)) code = CODE_OFF;
         if (code == CODE_AUTO || code == CODE_AUTO_ALT) begin
            auto_on = 1'b1;
            if (mains) begin
               relays[R_CHANGE] = 1'b0;
               open_phase(PH_MAINS_HOLD, cfg.hold_seconds);
            end else begin
               open_phase(PH_WAIT, 8'd1);
            end
         end else if (code == CODE_START) begin
            auto_on         = 1'b0;
            relays[R_STOP]  = 1'b1;
            relays[R_ON]    = 1'b1;
            relays[R_START] = 1'b1;
            run_on          = 1'b1;
         end else if (code == CODE_MAINTAIN) begin
            relays[R_START] = 1'b0;
            auto_on         = 1'b0;
         end else begin
            auto_on = 1'b0;
            open_phase(PH_OFF_HOLD, cfg.hold_seconds);
         end
      end
   endfunction

   // Applies one item to the state copy and returns the relay state it leaves.
   function automatic result_type advance_controller(input logic [1:0] kind,
                                                     input logic [2:0] buttons,
                                                     input logic mains);
      result_type r;
      case (kind)
         KIND_TICK: begin
            tick_cnt = tick_cnt + 1'b1;
            if (32'(tick_cnt) == 32'(cfg.ticks_per_second)) begin
               tick_cnt = '0;
               count_second(mains);
            end
         end
         KIND_SCAN: begin
            take_scan(buttons, mains);
         end
         KIND_STOP: begin
            off_latch = 1'b1;
            auto_on   = 1'b0;
            run_on    = 1'b0;
         end
         default: begin
         end
      endcase
      r.stop_relay       = relays[R_STOP];
      r.changeover_relay = relays[R_CHANGE];
      r.start_relay      = relays[R_START];
      r.on_relay         = relays[R_ON];
      r.square_out       = square;
      r.running          = run_on;
      r.cooling          = cool_on;
      r.auto_mode        = auto_on;
      return r;
   endfunction

   // Register writes, result comparison and prediction, all on the clock edge.
   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      logic       bad;
      if (reset) begin
         clear_controller();
         relay_states_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_IDX_W+1:2])
               REG_RUN_LIMIT:      cfg.run_limit        = pwdata[15:0];
               REG_COOLDOWN_LIMIT: cfg.cooldown_limit   = pwdata[15:0];
               REG_TICKS_PER_SEC:  cfg.ticks_per_second = pwdata[15:0];
               REG_CRANK_SECONDS:  cfg.crank_seconds    = pwdata[7:0];
               REG_SETTLE_SECONDS: cfg.settle_seconds   = pwdata[7:0];
               REG_HOLD_SECONDS:   cfg.hold_seconds     = pwdata[7:0];
               default: begin
               end
            endcase
         end

         // Compare before predicting so that a stray result is never paired
         // with the item accepted on the same edge.
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_stop_relay, rsp_changeover_relay, rsp_start_relay, rsp_on_relay,
                   rsp_square_out, rsp_running, rsp_cooling, rsp_auto_mode};
            if (relay_states_due.size() == 0) begin
               if (fail_total < 10)
                  $display("%0t: result %0d arrived with nothing due, actual %b",
                           $realtime, result_index, got);
               fail_total++;
            end else begin
               want = relay_states_due.pop_front();
               bad  = 1'b0;
               for (int i = 0; i < 8; i++) begin
                  if (got[7-i] !== want[7-i]) begin
                     bad = 1'b1;
                     if (fail_total < 10)
                        $display("%0t: result %0d %s: expected %b, actual %b", $realtime,
                                 result_index, field_name[i], want[7-i], got[7-i]);
                  end
               end
               if (bad) fail_total++;
            end
            result_index++;
         end

         if (req_valid && !req_stall)
            relay_states_due.push_back(advance_controller(req_kind, req_buttons,
                                                          req_mains_present));
      end
      mismatch_count <= fail_total;
      outstanding    <= relay_states_due.size();
   end

endmodule

// ----- bench/tb_generator_transfer_switch_ctrl.sv -----
`timescale 1ns / 1ps

module tb_generator_transfer_switch_ctrl;
   import gtsc_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         DRAIN_CYCLES = 4;
   localparam int         END_CYCLES   = 10;
   localparam int         HOLD_OFF_CYCLES = 300;
   localparam int         HOLD_OFF_AFTER  = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_kind = KIND_UNUSED;
   logic [2:0]            req_buttons = '0;
   logic                  req_mains_present = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_stop_relay;
   logic                  rsp_changeover_relay;
   logic                  rsp_start_relay;
   logic                  rsp_on_relay;
   logic                  rsp_square_out;
   logic                  rsp_running;
   logic                  rsp_cooling;
   logic                  rsp_auto_mode;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int   mismatch_count;
   int   outstanding;
   int   items_sent = 0;
   logic mains_now  = 1'b0;

   always #5 clock = ~clock;

   generator_transfer_switch_ctrl dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_buttons         (req_buttons),
      .req_mains_present   (req_mains_present),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_stop_relay      (rsp_stop_relay),
      .rsp_changeover_relay(rsp_changeover_relay),
      .rsp_start_relay     (rsp_start_relay),
      .rsp_on_relay        (rsp_on_relay),
      .rsp_square_out      (rsp_square_out),
      .rsp_running         (rsp_running),
      .rsp_cooling         (rsp_cooling),
      .rsp_auto_mode       (rsp_auto_mode),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   transfer_switch_checker switch_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_buttons         (req_buttons),
      .req_mains_present   (req_mains_present),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_stop_relay      (rsp_stop_relay),
      .rsp_changeover_relay(rsp_changeover_relay),
      .rsp_start_relay     (rsp_start_relay),
      .rsp_on_relay        (rsp_on_relay),
      .rsp_square_out      (rsp_square_out),
      .rsp_running         (rsp_running),
      .rsp_cooling         (rsp_cooling),
      .rsp_auto_mode       (rsp_auto_mode),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .pready              (pready),
      .mismatch_count      (mismatch_count),
      .outstanding         (outstanding)
   );

   // Offers one item and returns on the edge at which it is accepted.
   task automatic offer(input logic [1:0] kind, input logic [2:0] buttons, input logic mains);
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_buttons       <= buttons;
      req_mains_present <= mains;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent <= items_sent + 1;
   endtask

   // Drops valid and waits until every result due has come back.
   task automatic wait_drained(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Setup cycle, access cycle, then back to idle on the register port.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input int run_lim, input int cool_lim, input int tps,
                                 input int crank, input int settle, input int hold);
      write_reg(REG_RUN_LIMIT, run_lim);
      write_reg(REG_COOLDOWN_LIMIT, cool_lim);
      write_reg(REG_TICKS_PER_SEC, tps);
      write_reg(REG_CRANK_SECONDS, crank);
      write_reg(REG_SETTLE_SECONDS, settle);
      write_reg(REG_HOLD_SECONDS, hold);
   endtask

   // Random items in bursts. Mostly ticks, so that timed phases run to their
   // end, with scans biased towards auto and start; mains changes rarely.
   task automatic random_items(input int count, input int tick_permille);
      int         burst;
      int         gap;
      int         roll;
      logic [1:0] kind;
      logic [2:0] buttons;
      burst = $urandom_range(1, 40);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 999);
         if (roll < tick_permille) kind = KIND_TICK;
         else if (roll < tick_permille + (1000 - tick_permille) * 3 / 4) kind = KIND_SCAN;
         else if (roll < tick_permille + (1000 - tick_permille) * 7 / 8) kind = KIND_STOP;
         else kind = KIND_UNUSED;
         roll = $urandom_range(0, 19);
         if (roll < 5) buttons = CODE_AUTO;
         else if (roll < 8) buttons = CODE_AUTO_ALT;
         else if (roll < 11) buttons = CODE_START;
         else if (roll < 13) buttons = CODE_MAINTAIN;
         else buttons = $urandom_range(0, 7);
         if ($urandom_range(0, 15) == 0) mains_now = ~mains_now;
         offer(kind, buttons, mains_now);
         burst--;
         if (burst == 0 && n < count - 1) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst = $urandom_range(1, 40);
         end
      end
   endtask

   // Receiver: stretches of random stall density, and once a long hold-off
   // while the sender keeps offering items.
   initial begin : receiver
      int seg;
      int pct;
      bit held;
      held = 1'b0;
      forever begin
         seg = $urandom_range(1, 60);
         case ($urandom_range(0, 4))
            0, 1:    pct = 0;
            2:       pct = 25;
            3:       pct = 50;
            default: pct = 75;
         endcase
         repeat (seg) begin
            @(posedge clock);
            if (!held && items_sent >= HOLD_OFF_AFTER) begin
               rsp_stall <= 1'b1;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
               held = 1'b1;
            end
            rsp_stall <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   initial begin : timeout
      #40_000_000;
      $display("tb_generator_transfer_switch_ctrl failed");
      $finish;
   end

   initial begin : stimulus
      int run_lim;
      int cool_lim;
      int tps;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: no second can pass, so only mode changes are seen.
      offer(KIND_UNUSED, 3'b111, 1'b1);
      offer(KIND_SCAN, CODE_START, 1'b0);
      offer(KIND_SCAN, CODE_MAINTAIN, 1'b1);
      offer(KIND_STOP, CODE_MAINTAIN, 1'b0);
      offer(KIND_UNUSED, CODE_MAINTAIN, 1'b0);
      wait_drained(DRAIN_CYCLES);

      // Every tick a second and every phase one second long.
      apply_settings(3, 2, 1, 1, 1, 1);
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);
      offer(KIND_SCAN, CODE_AUTO, 1'b0);       // latched stop forces the off path
      offer(KIND_SCAN, CODE_START, 1'b0);      // ignored while the hold runs
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);
      offer(KIND_SCAN, CODE_AUTO_ALT, 1'b1);   // auto with mains returns the load
      offer(KIND_TICK, CODE_MAINTAIN, 1'b1);
      offer(KIND_SCAN, CODE_MAINTAIN, 1'b1);   // latched after mains hold
      offer(KIND_TICK, CODE_MAINTAIN, 1'b1);
      offer(KIND_SCAN, CODE_AUTO, 1'b0);       // auto without mains: wait
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);   // crank
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);   // settle
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);   // changeover to the generator
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);   // run limit reached, cooldown
      offer(KIND_SCAN, CODE_AUTO, 1'b0);       // cooling forces the off path
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);   // cooldown ends
      offer(KIND_SCAN, 3'b101, 1'b0);          // off and auto together
      offer(KIND_TICK, CODE_MAINTAIN, 1'b0);
      wait_drained(DRAIN_CYCLES);

      // Zero limits: every second stops running and clears the cooldown at once.
      apply_settings(0, 0, 1, 1, 1, 1);
      random_items(200, 700);

      // Limits and prescaler never shrink, so counters never sit above them.
      run_lim  = 0;
      cool_lim = 0;
      tps      = 1;
      for (int p = 0; p < 4; p++) begin
         run_lim  += $urandom_range(2, 8);
         cool_lim += $urandom_range(1, 5);
         if (p > 0 && tps < 3) tps += $urandom_range(0, 1);
         wait_drained(DRAIN_CYCLES);
         apply_settings(run_lim, cool_lim, tps, $urandom_range(1, 6),
                        $urandom_range(1, 6), $urandom_range(1, 4));
         random_items(200, 700);
      end

      // Largest limits and phase lengths.
      wait_drained(DRAIN_CYCLES);
      apply_settings(16'hFFFF, 16'hFFFF, 3, 8'hFF, 8'hFF, 8'hFF);
      random_items(300, 700);

      // Largest prescaler.
      wait_drained(DRAIN_CYCLES);
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, $urandom_range(1, 255),
                     $urandom_range(1, 255), $urandom_range(1, 255));
      random_items(60, 700);

      // Zero prescaler: the tick counter would have to wrap before a second
      // passes, so these ticks only count up.
      wait_drained(DRAIN_CYCLES);
      apply_settings(16'hFFFF, 16'hFFFF, 0, $urandom_range(1, 4),
                     $urandom_range(1, 4), $urandom_range(1, 4));
      random_items(60, 990);

      wait_drained(END_CYCLES);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb_generator_transfer_switch_ctrl passed");
      end else begin
         $display("tb_generator_transfer_switch_ctrl failed");
      end
      $finish;
   end

endmodule

// ----- generator_transfer_switch_ctrl.f -----
design/gtsc_pkg.sv
design/gtsc_csr.sv
design/gtsc_step.sv
design/generator_transfer_switch_ctrl.sv
bench/transfer_switch_checker.sv
bench/tb_generator_transfer_switch_ctrl.sv
